@@ design/rpp_pkg.sv @@
// ---------------------------------------------------------------------------
// rpp_pkg
// Shared widths, constants and handshake structs of the relative position
// core and its serial arithmetic units.
// ---------------------------------------------------------------------------
package rpp_pkg;

   // fixed point formats
   localparam int QUAT_FRAC_BITS = 14;
   localparam int RND_SH         = 2 * QUAT_FRAC_BITS;   // fraction bits of R entries

   localparam int POS_W  = 32;                // position / result word
   localparam int Q_W    = 16;                // quaternion component
   localparam int D_W    = POS_W + 1;         // exact position difference
   localparam int PR_W   = 2 * Q_W;           // quaternion product
   localparam int R_W    = PR_W + 2;          // rotation matrix entry
   localparam int ACC_W  = R_W + D_W + 3;     // sum of three products
   localparam int RQ_W   = ACC_W - RND_SH;    // rounded magnitude before saturation
   localparam int SQ_W   = 2 * POS_W;         // sum of squares
   localparam int ROOT_W = SQ_W / 2;

   // serial multiplier: one DIG_W-bit digit of b per cycle
   localparam int MUL_W      = 36;
   localparam int MUL_P_W    = 2 * MUL_W;
   localparam int DIG_W      = 4;
   localparam int MUL_STEPS  = MUL_W / DIG_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

   // square root: one root bit per cycle
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // function codes of an input word
   localparam logic FUNC_REF    = 1'b0;
   localparam logic FUNC_TARGET = 1'b1;

   localparam logic signed [R_W-1:0]  R_ONE    = R_W'(1) <<< RND_SH;
   localparam logic [ACC_W-1:0]       RND_HALF = ACC_W'(1) << (RND_SH - 1);
   localparam logic [D_W-1:0]         SAT_POS  = D_W'(32'h7FFF_FFFF);
   localparam logic [D_W-1:0]         SAT_NEG  = D_W'(33'h0_8000_0000);

   typedef struct packed {
      logic                      start;
      logic signed [MUL_W-1:0]   a;
      logic signed [MUL_W-1:0]   b;
   } mul_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [MUL_P_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SQ_W-1:0]   radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

@@ design/rpp_if.sv @@
// ---------------------------------------------------------------------------
// rpp_req_if / rpp_rsp_if
// Valid/ready channels carrying pose words in and relative position words
// out.
// ---------------------------------------------------------------------------
interface rpp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [rpp_pkg::POS_W-1:0]    pos_x;
   logic signed [rpp_pkg::POS_W-1:0]    pos_y;
   logic signed [rpp_pkg::POS_W-1:0]    pos_z;
   logic signed [rpp_pkg::Q_W-1:0]      quat_w;
   logic signed [rpp_pkg::Q_W-1:0]      quat_x;
   logic signed [rpp_pkg::Q_W-1:0]      quat_y;
   logic signed [rpp_pkg::Q_W-1:0]      quat_z;
   logic                                pose_ok;

   modport source (output valid, func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                   quat_z, pose_ok, input ready);
   modport sink   (input valid, func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                   quat_z, pose_ok, output ready);
endinterface

interface rpp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rpp_pkg::POS_W-1:0]    rel_x;
   logic signed [rpp_pkg::POS_W-1:0]    rel_y;
   logic signed [rpp_pkg::POS_W-1:0]    rel_z;
   logic [rpp_pkg::POS_W-1:0]           distance;
   logic                                result_ok;

   modport source (output valid, rel_x, rel_y, rel_z, distance, result_ok, input ready);
   modport sink   (input valid, rel_x, rel_y, rel_z, distance, result_ok, output ready);
endinterface

@@ design/rpp_mul.sv @@
// ---------------------------------------------------------------------------
// rpp_mul
// Signed digit-serial multiplier: magnitudes, one 4-bit digit of b per
// cycle, sign applied in a final registered step.
// ---------------------------------------------------------------------------
module rpp_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rpp_pkg::mul_req_type mreq,
   output rpp_pkg::mul_rsp_type mrsp
);

   logic                               run_ff;
   logic                               fin_ff;
   logic                               done_ff;
   logic [rpp_pkg::MUL_CNT_W-1:0]      cnt_ff;
   logic                               neg_ff;
   logic [rpp_pkg::MUL_P_W-1:0]        a_ff;
   logic [rpp_pkg::MUL_W-1:0]          b_ff;
   logic [rpp_pkg::MUL_P_W-1:0]        acc_ff;
   logic signed [rpp_pkg::MUL_P_W-1:0] prod_ff;

   logic [rpp_pkg::MUL_W-1:0]          mag_a;
   logic [rpp_pkg::MUL_W-1:0]          mag_b;
   logic [rpp_pkg::MUL_P_W-1:0]        part;

   // operand magnitudes
   assign mag_a = mreq.a[rpp_pkg::MUL_W-1] ? rpp_pkg::MUL_W'(-mreq.a) : mreq.a;
   assign mag_b = mreq.b[rpp_pkg::MUL_W-1] ? rpp_pkg::MUL_W'(-mreq.b) : mreq.b;

   // partial product of the current digit
   assign part = rpp_pkg::MUL_P_W'(a_ff * b_ff[rpp_pkg::DIG_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (mreq.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            neg_ff <= mreq.a[rpp_pkg::MUL_W-1] ^ mreq.b[rpp_pkg::MUL_W-1];
            a_ff   <= rpp_pkg::MUL_P_W'(mag_a);
            b_ff   <= mag_b;
            acc_ff <= '0;
         end else if (run_ff) begin
            acc_ff <= acc_ff + part;
            a_ff   <= a_ff << rpp_pkg::DIG_W;
            b_ff   <= b_ff >> rpp_pkg::DIG_W;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rpp_pkg::MUL_CNT_W'(rpp_pkg::MUL_STEPS - 1)) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end
         // apply sign
         if (fin_ff) begin
            prod_ff <= neg_ff ? -signed'(acc_ff) : signed'(acc_ff);
            done_ff <= 1'b1;
         end
      end
   end

   assign mrsp.done = done_ff;
   assign mrsp.prod = prod_ff;

endmodule

@@ design/rpp_sqrt.sv @@
// ---------------------------------------------------------------------------
// rpp_sqrt
// Restoring integer square root, two radicand bits and one root bit per
// cycle. Root holds until the next start.
// ---------------------------------------------------------------------------
module rpp_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rpp_pkg::sqrt_req_type sreq,
   output rpp_pkg::sqrt_rsp_type srsp
);

   logic                             run_ff;
   logic                             done_ff;
   logic [rpp_pkg::ROOT_CNT_W-1:0]   cnt_ff;
   logic [rpp_pkg::SQ_W-1:0]         rad_ff;
   logic [rpp_pkg::ROOT_W+1:0]       rem_ff;
   logic [rpp_pkg::ROOT_W-1:0]       root_ff;

   logic [rpp_pkg::ROOT_W+3:0]       rem_sh;
   logic [rpp_pkg::ROOT_W+3:0]       trial;
   logic                             fits;

   // next remainder digit and trial value
   assign rem_sh = {rem_ff, rad_ff[rpp_pkg::SQ_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sreq.start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= sreq.radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (run_ff) begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= fits ? (rpp_pkg::ROOT_W + 2)'(rem_sh - trial)
                            : rem_sh[rpp_pkg::ROOT_W+1:0];
            root_ff <= {root_ff[rpp_pkg::ROOT_W-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == rpp_pkg::ROOT_CNT_W'(rpp_pkg::ROOT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign srsp.done = done_ff;
   assign srsp.root = root_ff;

endmodule

@@ design/relative_pose_position_core.sv @@
// ---------------------------------------------------------------------------
// relative_pose_position_core
// Position of a target pose in the frame of a stored reference pose.
// ---------------------------------------------------------------------------
// A reference word (func 0) stores its position and validity and turns its
// quaternion into the rotation matrix; it gives no result. A target word
// (func 1) gives one result word, R transposed times the position difference
// plus its length: twelve products on the shared 4-bit-digit multiplier,
// three rounding steps and a bit-serial square root. A target word with an
// invalid pose or reference gives an all-zero word. One word is worked on at
// a time; a finished result sits in the output register while the next word
// is accepted.
// ---------------------------------------------------------------------------
module relative_pose_position_core (
   input  logic        clock,
   input  logic        reset,
   rpp_req_if.sink     req_ch,
   rpp_rsp_if.source   rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_QMUL, ST_RBLD, ST_RMUL, ST_RND, ST_SQR, ST_ROOT, ST_OUT
   } state_type;

   // quaternion product slots
   localparam logic [3:0] P_YY = 4'd0;
   localparam logic [3:0] P_ZZ = 4'd1;
   localparam logic [3:0] P_XX = 4'd2;
   localparam logic [3:0] P_XY = 4'd3;
   localparam logic [3:0] P_WZ = 4'd4;
   localparam logic [3:0] P_XZ = 4'd5;
   localparam logic [3:0] P_WY = 4'd6;
   localparam logic [3:0] P_YZ = 4'd7;
   localparam logic [3:0] P_WX = 4'd8;
   localparam logic [1:0] LAST_AXIS = 2'd2;

   state_type                           state_ff;
   logic [3:0]                          step_ff;
   logic [1:0]                          i_ff;
   logic [1:0]                          j_ff;
   logic                                wait_ff;
   logic                                mul_go_ff;
   logic                                sqrt_go_ff;
   logic                                zero_ff;
   logic                                ref_valid_ff;
   logic signed [rpp_pkg::POS_W-1:0]    ref_pos_ff [3];
   logic signed [rpp_pkg::Q_W-1:0]      q_w_ff, q_x_ff, q_y_ff, q_z_ff;
   logic signed [rpp_pkg::PR_W-1:0]     pr_ff [9];
   logic signed [rpp_pkg::R_W-1:0]      r_ff [3][3];
   logic signed [rpp_pkg::D_W-1:0]      d_ff [3];
   logic signed [rpp_pkg::ACC_W-1:0]    acc_ff;
   logic signed [rpp_pkg::POS_W-1:0]    rel_ff [3];
   logic [rpp_pkg::SQ_W-1:0]            sq_ff;

   logic                                rsp_valid_ff;
   logic signed [rpp_pkg::POS_W-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [rpp_pkg::POS_W-1:0]           rsp_dist_ff;
   logic                                rsp_ok_ff;

   rpp_pkg::mul_req_type                mul_req;
   rpp_pkg::mul_rsp_type                mul_rsp;
   rpp_pkg::sqrt_req_type               sqrt_req;
   rpp_pkg::sqrt_rsp_type               sqrt_rsp;

   logic signed [rpp_pkg::MUL_W-1:0]    mul_a;
   logic signed [rpp_pkg::MUL_W-1:0]    mul_b;
   logic signed [rpp_pkg::POS_W-1:0]    pos_in [3];
   logic                                valid_pair;
   logic                                rsp_load;

   logic                                acc_neg;
   logic [rpp_pkg::ACC_W-1:0]           rnd_mag;
   logic [rpp_pkg::RQ_W-1:0]            rnd_q;
   logic [rpp_pkg::D_W-1:0]             rnd_lim;
   logic [rpp_pkg::D_W-1:0]             rnd_lo;
   logic [rpp_pkg::D_W-1:0]             rnd_val;

   function automatic logic signed [rpp_pkg::R_W-1:0] dbl(
      input logic signed [rpp_pkg::PR_W-1:0] p);
      return rpp_pkg::R_W'(p) <<< 1;
   endfunction

   assign pos_in[0]  = req_ch.pos_x;
   assign pos_in[1]  = req_ch.pos_y;
   assign pos_in[2]  = req_ch.pos_z;
   assign valid_pair = ref_valid_ff && req_ch.pose_ok;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // output register free or being emptied this cycle
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_QMUL: begin
            case (step_ff)
               P_YY: begin mul_a = rpp_pkg::MUL_W'(q_y_ff); mul_b = rpp_pkg::MUL_W'(q_y_ff); end
               P_ZZ: begin mul_a = rpp_pkg::MUL_W'(q_z_ff); mul_b = rpp_pkg::MUL_W'(q_z_ff); end
               P_XX: begin mul_a = rpp_pkg::MUL_W'(q_x_ff); mul_b = rpp_pkg::MUL_W'(q_x_ff); end
               P_XY: begin mul_a = rpp_pkg::MUL_W'(q_x_ff); mul_b = rpp_pkg::MUL_W'(q_y_ff); end
               P_WZ: begin mul_a = rpp_pkg::MUL_W'(q_w_ff); mul_b = rpp_pkg::MUL_W'(q_z_ff); end
               P_XZ: begin mul_a = rpp_pkg::MUL_W'(q_x_ff); mul_b = rpp_pkg::MUL_W'(q_z_ff); end
               P_WY: begin mul_a = rpp_pkg::MUL_W'(q_w_ff); mul_b = rpp_pkg::MUL_W'(q_y_ff); end
               P_YZ: begin mul_a = rpp_pkg::MUL_W'(q_y_ff); mul_b = rpp_pkg::MUL_W'(q_z_ff); end
               P_WX: begin mul_a = rpp_pkg::MUL_W'(q_w_ff); mul_b = rpp_pkg::MUL_W'(q_x_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_RMUL: begin
            // R transposed: column i of R against d
            mul_a = rpp_pkg::MUL_W'(r_ff[j_ff][i_ff]);
            mul_b = rpp_pkg::MUL_W'(d_ff[j_ff]);
         end
         ST_SQR: begin
            mul_a = rpp_pkg::MUL_W'(rel_ff[i_ff]);
            mul_b = rpp_pkg::MUL_W'(rel_ff[i_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_req.start = mul_go_ff;
   assign mul_req.a     = mul_a;
   assign mul_req.b     = mul_b;
   assign sqrt_req.start    = sqrt_go_ff;
   assign sqrt_req.radicand = sq_ff;

   // round to nearest, ties away from zero, then saturate
   assign acc_neg = acc_ff[rpp_pkg::ACC_W-1];
   assign rnd_mag = acc_neg ? (rpp_pkg::RND_HALF - rpp_pkg::ACC_W'(acc_ff))
                            : (rpp_pkg::ACC_W'(acc_ff) + rpp_pkg::RND_HALF);
   assign rnd_q   = rnd_mag[rpp_pkg::ACC_W-1:rpp_pkg::RND_SH];
   assign rnd_lim = acc_neg ? rpp_pkg::SAT_NEG : rpp_pkg::SAT_POS;
   assign rnd_lo  = (rnd_q > rpp_pkg::RQ_W'(rnd_lim)) ? rnd_lim : rnd_q[rpp_pkg::D_W-1:0];
   assign rnd_val = acc_neg ? (rpp_pkg::D_W'(0) - rnd_lo) : rnd_lo;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         wait_ff      <= 1'b0;
         mul_go_ff    <= 1'b0;
         sqrt_go_ff   <= 1'b0;
         zero_ff      <= 1'b0;
         ref_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff  <= 1'b0;
         sqrt_go_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  if (req_ch.func == rpp_pkg::FUNC_REF) begin
                     for (int k = 0; k < 3; k++) begin
                        ref_pos_ff[k] <= pos_in[k];
                     end
                     q_w_ff       <= req_ch.quat_w;
                     q_x_ff       <= req_ch.quat_x;
                     q_y_ff       <= req_ch.quat_y;
                     q_z_ff       <= req_ch.quat_z;
                     ref_valid_ff <= req_ch.pose_ok;
                     step_ff      <= P_YY;
                     state_ff     <= ST_QMUL;
                  end else begin
                     for (int k = 0; k < 3; k++) begin
                        d_ff[k] <= rpp_pkg::D_W'(pos_in[k]) - rpp_pkg::D_W'(ref_pos_ff[k]);
                     end
                     zero_ff  <= !valid_pair;
                     i_ff     <= '0;
                     j_ff     <= '0;
                     state_ff <= valid_pair ? ST_RMUL : ST_OUT;
                  end
               end
            end
            ST_QMUL: begin
               if (!wait_ff) begin
                  mul_go_ff <= 1'b1;
                  wait_ff   <= 1'b1;
               end else if (mul_rsp.done) begin
                  wait_ff        <= 1'b0;
                  pr_ff[step_ff] <= mul_rsp.prod[rpp_pkg::PR_W-1:0];
                  if (step_ff == P_WX) begin
                     state_ff <= ST_RBLD;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end
            ST_RBLD: begin
               r_ff[0][0] <= rpp_pkg::R_ONE - dbl(pr_ff[P_YY]) - dbl(pr_ff[P_ZZ]);
               r_ff[0][1] <= dbl(pr_ff[P_XY]) - dbl(pr_ff[P_WZ]);
               r_ff[0][2] <= dbl(pr_ff[P_XZ]) + dbl(pr_ff[P_WY]);
               r_ff[1][0] <= dbl(pr_ff[P_XY]) + dbl(pr_ff[P_WZ]);
               r_ff[1][1] <= rpp_pkg::R_ONE - dbl(pr_ff[P_XX]) - dbl(pr_ff[P_ZZ]);
               r_ff[1][2] <= dbl(pr_ff[P_YZ]) - dbl(pr_ff[P_WX]);
               r_ff[2][0] <= dbl(pr_ff[P_XZ]) - dbl(pr_ff[P_WY]);
               r_ff[2][1] <= dbl(pr_ff[P_YZ]) + dbl(pr_ff[P_WX]);
               r_ff[2][2] <= rpp_pkg::R_ONE - dbl(pr_ff[P_XX]) - dbl(pr_ff[P_YY]);
               state_ff   <= ST_IDLE;
            end
            ST_RMUL: begin
               if (!wait_ff) begin
                  mul_go_ff <= 1'b1;
                  wait_ff   <= 1'b1;
               end else if (mul_rsp.done) begin
                  wait_ff <= 1'b0;
                  acc_ff  <= ((j_ff == '0) ? '0 : acc_ff) + rpp_pkg::ACC_W'(mul_rsp.prod);
                  if (j_ff == LAST_AXIS) begin
                     j_ff     <= '0;
                     state_ff <= ST_RND;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            ST_RND: begin
               rel_ff[i_ff] <= rnd_val[rpp_pkg::POS_W-1:0];
               if (i_ff == LAST_AXIS) begin
                  i_ff     <= '0;
                  sq_ff    <= '0;
                  state_ff <= ST_SQR;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_RMUL;
               end
            end
            ST_SQR: begin
               if (!wait_ff) begin
                  mul_go_ff <= 1'b1;
                  wait_ff   <= 1'b1;
               end else if (mul_rsp.done) begin
                  wait_ff <= 1'b0;
                  sq_ff   <= sq_ff + mul_rsp.prod[rpp_pkg::SQ_W-1:0];
                  if (i_ff == LAST_AXIS) begin
                     sqrt_go_ff <= 1'b1;
                     state_ff   <= ST_ROOT;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end
            end
            ST_ROOT: begin
               if (sqrt_rsp.done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // load the output register once it is free
               if (rsp_load) begin
                  rsp_x_ff     <= zero_ff ? '0 : rel_ff[0];
                  rsp_y_ff     <= zero_ff ? '0 : rel_ff[1];
                  rsp_z_ff     <= zero_ff ? '0 : rel_ff[2];
                  rsp_dist_ff  <= zero_ff ? '0 : sqrt_rsp.root;
                  rsp_ok_ff    <= !zero_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.rel_x     = rsp_x_ff;
   assign rsp_ch.rel_y     = rsp_y_ff;
   assign rsp_ch.rel_z     = rsp_z_ff;
   assign rsp_ch.distance  = rsp_dist_ff;
   assign rsp_ch.result_ok = rsp_ok_ff;

   rpp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mul_req),
      .mrsp  (mul_rsp)
   );

   rpp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .sreq  (sqrt_req),
      .srsp  (sqrt_rsp)
   );

endmodule

@@ design/rpp_checker.sv @@
// ---------------------------------------------------------------------------
// rpp_checker
// Port-level checks of the relative position core, bound to the top level.
// ---------------------------------------------------------------------------
module rpp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rpp_pkg::POS_W-1:0]   rel_x,
   input logic signed [rpp_pkg::POS_W-1:0]   rel_y,
   input logic signed [rpp_pkg::POS_W-1:0]   rel_z,
   input logic [rpp_pkg::POS_W-1:0]          distance,
   input logic                               result_ok
);

   // a stalled result word stays valid and keeps rel_x, distance and result_ok
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rel_x) && $stable(distance)
         && $stable(result_ok))
      else $error("result word changed while stalled");

   // a word without a valid pair of poses carries only zeros
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !result_ok |-> rel_x == '0 && rel_y == '0 && rel_z == '0
         && distance == '0)
      else $error("invalid result word is not all zero");

   // one word at a time: input closes after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a word is in flight");

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule

bind relative_pose_position_core rpp_checker u_rpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rel_x     (rsp_ch.rel_x),
   .rel_y     (rsp_ch.rel_y),
   .rel_z     (rsp_ch.rel_z),
   .distance  (rsp_ch.distance),
   .result_ok (rsp_ch.result_ok)
);

@@ dv/tb_relative_pose_position_core.sv @@
// ---------------------------------------------------------------------------
// tb_relative_pose_position_core
// Self-checking bench for the relative position core: drives reference and
// target pose words with random idle gaps and a long result stall, predicts
// each result word in a scoreboard and compares it field by field.
// ---------------------------------------------------------------------------
class pose_scoreboard;
   typedef struct packed {
      logic signed [31:0] rel_x;
      logic signed [31:0] rel_y;
      logic signed [31:0] rel_z;
      logic [31:0]        distance;
      logic               result_ok;
   } rel_word_type;

   logic signed [31:0] ref_pos [3];
   logic signed [15:0] ref_quat [4];
   bit                 ref_ok;
   rel_word_type       pending[$];
   int                 errors;

   function new();
      foreach (ref_pos[i]) ref_pos[i] = '0;
      foreach (ref_quat[i]) ref_quat[i] = '0;
      ref_ok = 0;
      errors = 0;
   endfunction

   // round to nearest, ties away from zero, then clamp to int32
   function automatic logic signed [31:0] round_clamp(logic signed [127:0] acc);
      logic [127:0] mag;
      logic [127:0] q;
      bit           neg;
      neg = acc[127];
      mag = neg ? -acc : acc;
      q = (mag + (128'd1 << (rpp_pkg::RND_SH - 1))) >> rpp_pkg::RND_SH;
      if (neg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         return -$signed(q[32:0]);
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // note an accepted pose word
   function void note_pose(logic func, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [15:0] qw,
                           logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic ok);
      logic signed [127:0] w, x, y, z, one;
      logic signed [127:0] r [3][3];
      logic signed [127:0] d [3];
      logic signed [127:0] acc;
      logic signed [31:0]  rel [3];
      logic [63:0]         sq;
      logic [63:0]         root;
      rel_word_type        e;
      if (func == rpp_pkg::FUNC_REF) begin
         ref_pos[0] = px; ref_pos[1] = py; ref_pos[2] = pz;
         ref_quat[0] = qw; ref_quat[1] = qx; ref_quat[2] = qy; ref_quat[3] = qz;
         ref_ok = ok;
         return;
      end
      e = '0;
      if (ref_ok && ok) begin
         one = 128'sd1 <<< rpp_pkg::RND_SH;
         w = ref_quat[0]; x = ref_quat[1]; y = ref_quat[2]; z = ref_quat[3];
         r[0][0] = one - 2*y*y - 2*z*z;
         r[0][1] = 2*x*y - 2*w*z;
         r[0][2] = 2*x*z + 2*w*y;
         r[1][0] = 2*x*y + 2*w*z;
         r[1][1] = one - 2*x*x - 2*z*z;
         r[1][2] = 2*y*z - 2*w*x;
         r[2][0] = 2*x*z - 2*w*y;
         r[2][1] = 2*y*z + 2*w*x;
         r[2][2] = one - 2*x*x - 2*y*y;
         d[0] = 128'(px) - 128'(ref_pos[0]);
         d[1] = 128'(py) - 128'(ref_pos[1]);
         d[2] = 128'(pz) - 128'(ref_pos[2]);
         sq = 0;
         for (int i = 0; i < 3; i++) begin
            acc = r[0][i]*d[0] + r[1][i]*d[1] + r[2][i]*d[2];
            rel[i] = round_clamp(acc);
            sq += 64'(64'(rel[i]) * 64'(rel[i]));
         end
         root = floor_sqrt(sq);
         e.rel_x = rel[0]; e.rel_y = rel[1]; e.rel_z = rel[2];
         e.distance = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
         e.result_ok = 1'b1;
      end
      pending.push_back(e);
   endfunction

   // compare a result word with the oldest expectation
   function void check_result(rel_word_type got);
      rel_word_type e;
      if (pending.size() == 0) begin
         $error("result word with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.rel_x !== e.rel_x) begin
         $error("rel_x exp %0d got %0d", e.rel_x, got.rel_x); errors++;
      end
      if (got.rel_y !== e.rel_y) begin
         $error("rel_y exp %0d got %0d", e.rel_y, got.rel_y); errors++;
      end
      if (got.rel_z !== e.rel_z) begin
         $error("rel_z exp %0d got %0d", e.rel_z, got.rel_z); errors++;
      end
      if (got.distance !== e.distance) begin
         $error("distance exp %0d got %0d", e.distance, got.distance); errors++;
      end
      if (got.result_ok !== e.result_ok) begin
         $error("result_ok exp %0b got %0b", e.result_ok, got.result_ok); errors++;
      end
   endfunction
endclass

module tb_relative_pose_position_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpp_req_if req_ch ();
   rpp_rsp_if rsp_ch ();

   relative_pose_position_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   pose_scoreboard pose_sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 0;
   int  quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0; req_ch.func = 1'b0; req_ch.pose_ok = 1'b0;
      req_ch.pos_x = '0; req_ch.pos_y = '0; req_ch.pos_z = '0;
      req_ch.quat_w = '0; req_ch.quat_x = '0; req_ch.quat_y = '0; req_ch.quat_z = '0;
      rsp_ch.ready = 1'b0;
   end

   // check accepted result words and count quiet cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            pose_sb.check_result({rsp_ch.rel_x, rsp_ch.rel_y, rsp_ch.rel_z,
                                  rsp_ch.distance, rsp_ch.result_ok});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("relative_pose_position_core: mismatch");
         $finish;
      end
   end

   // result side ready, random stalls plus the long hold-off
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // long hold-off so the core fills and blocks its input
   initial begin
      @(negedge reset);
      repeat (15000) @(posedge clock);
      hold_off = 1;
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_quat();
      case ($urandom_range(4))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // offer one word and wait for acceptance; valid drops only while idling
   task automatic send_pose(logic func, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [15:0] qw,
                            logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1; req_ch.func <= func; req_ch.pose_ok <= ok;
      req_ch.pos_x <= px; req_ch.pos_y <= py; req_ch.pos_z <= pz;
      req_ch.quat_w <= qw; req_ch.quat_x <= qx; req_ch.quat_y <= qy; req_ch.quat_z <= qz;
      do @(posedge clock); while (!req_ch.ready);
      pose_sb.note_pose(func, px, py, pz, qw, qx, qy, qz, ok);
   endtask

   task automatic send_random(bit well_formed);
      logic func;
      func = well_formed ? ($urandom_range(3) != 0) : 1'($urandom_range(1));
      send_pose(func, rand_pos(), rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                rand_quat(), rand_quat(), well_formed ? ($urandom_range(9) != 0)
                                                      : 1'($urandom_range(1)));
   endtask

   initial begin
      pose_sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no reference yet, identity, extremes, invalid cases
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd65536, 0, 0, 0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_REF, 0, 0, 0, 16'sd16384, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd65536, 32'sd131072, -32'sd196608,
                0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd1, 32'sd1, 32'sd1, 0, 0, 0, 0, 1'b0);
      send_pose(rpp_pkg::FUNC_REF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_REF, 32'sd100, 32'sd200, 32'sd300,
                16'sd11585, 0, 0, 16'sd11585, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd65636, 32'sd200, 32'sd300, 0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd1, 32'sd3, -32'sd1, 0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_REF, 32'sd5, 32'sd5, 32'sd5, 16'sd16384, 0, 0, 0, 1'b0);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sd9, 32'sd9, 32'sd9, 0, 0, 0, 0, 1'b1);
      send_pose(rpp_pkg::FUNC_REF, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
      send_pose(rpp_pkg::FUNC_TARGET, 32'sh4000_0000, -32'sh4000_0000, 32'sh1234_5678,
                0, 0, 0, 0, 1'b1);

      // random: three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 46 : 0;
         recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 32 : 0;
         for (int n = 0; n < 180; n++)
            send_random($urandom_range(9) != 0);
      end
      req_ch.valid <= 1'b0;

      // drain, then allow the core to finish any trailing reference word
      while (pose_sb.pending.size() != 0 && quiet_cycles < STALL_LIMIT) @(posedge clock);
      repeat (400) @(posedge clock);
      if (pose_sb.errors == 0 && pose_sb.pending.size() == 0)
         $display("relative_pose_position_core: match");
      else
         $display("relative_pose_position_core: mismatch");
      $finish;
   end
endmodule
